>>> src/lsm_pkg.sv
// Shared types, constants and helpers of the linear symbol mapper.
package lsm_pkg;

	localparam int SYM_W    = 8;
	localparam int SAMP_W   = 16;
	localparam int MODE_W   = 3;
	localparam int BPS_W    = 4;
	localparam int QUAD_W   = 3;
	localparam int AMP_W    = 15;
	localparam int STEP_W   = 16;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int XY_W     = 32;
	localparam int ANG_W    = 24;
	localparam int SAT_W    = 40;
	localparam int CORDIC_STEPS = 17;

	localparam logic signed [XY_W-1:0]   CORDIC_X0  = 32'sd652032874;
	localparam logic signed [SAMP_W-1:0] UNIT_LEVEL = 16'sd16384;
	localparam logic signed [SAMP_W-1:0] QPSK_LEVEL = 16'sd11585;
	localparam logic signed [SAMP_W-1:0] OOK_LEVEL  = 16'sd23170;

	// arctan(2^-i) in units of 2^-24 turn
	localparam logic signed [ANG_W-1:0] ATAN_TURN24 [CORDIC_STEPS] = '{
		24'sd2097152, 24'sd1238021, 24'sd654136, 24'sd332050, 24'sd166669,
		24'sd83416, 24'sd41718, 24'sd20860, 24'sd10430, 24'sd5215,
		24'sd2608, 24'sd1304, 24'sd652, 24'sd326, 24'sd163, 24'sd81, 24'sd41
	};

	typedef enum logic [MODE_W-1:0] {
		MODE_ASK  = 3'd0,
		MODE_QAM  = 3'd1,
		MODE_PSK  = 3'd2,
		MODE_DPSK = 3'd3,
		MODE_BPSK = 3'd4,
		MODE_QPSK = 3'd5,
		MODE_OOK  = 3'd6
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE  = 3'd0,
		REG_BPS   = 3'd1,
		REG_QUAD  = 3'd2,
		REG_AMP   = 3'd3,
		REG_PHASE = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_FIX   = 2'd0,
		KIND_LEVEL = 2'd1,
		KIND_ROT   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [BPS_W-1:0]  bits_per_symbol;
		logic [QUAD_W-1:0] quad_bits;
		logic [AMP_W-1:0]  amplitude_step;
		logic [STEP_W-1:0] phase_step;
	} lsm_cfg_t;

	typedef struct packed {
		logic                     rot;
		logic [1:0]               quad;
		logic signed [XY_W-1:0]   x;
		logic signed [XY_W-1:0]   y;
		logic signed [ANG_W-1:0]  z;
		logic signed [SAMP_W-1:0] fix_i;
		logic signed [SAMP_W-1:0] fix_q;
		logic                     err;
	} lsm_stage_t;

	function automatic logic signed [SAMP_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
		if (v > SAT_W'(32767))
			return 16'sh7FFF;
		else if (v < -SAT_W'(32768))
			return 16'sh8000;
		else
			return v[SAMP_W-1:0];
	endfunction

endpackage

>>> src/lsm_regs.sv
// APB configuration registers of the linear symbol mapper.
module lsm_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [lsm_pkg::ADDR_W-1:0] paddr,
	input  logic [lsm_pkg::DATA_W-1:0] pwdata,
	output logic [lsm_pkg::DATA_W-1:0] prdata,
	output logic                      pready,
	output lsm_pkg::lsm_cfg_t         cfg
);
	import lsm_pkg::*;

	lsm_cfg_t cfg_q;
	logic     wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode            <= MODE_ASK;
			cfg_q.bits_per_symbol <= BPS_W'(1);
			cfg_q.quad_bits       <= QUAD_W'(1);
			cfg_q.amplitude_step  <= AMP_W'(16384);
			cfg_q.phase_step      <= STEP_W'(32768);
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_MODE:  cfg_q.mode            <= pwdata[MODE_W-1:0];
				REG_BPS:   cfg_q.bits_per_symbol <= pwdata[BPS_W-1:0];
				REG_QUAD:  cfg_q.quad_bits       <= pwdata[QUAD_W-1:0];
				REG_AMP:   cfg_q.amplitude_step  <= pwdata[AMP_W-1:0];
				REG_PHASE: cfg_q.phase_step      <= pwdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_MODE:  prdata = DATA_W'(cfg_q.mode);
			REG_BPS:   prdata = DATA_W'(cfg_q.bits_per_symbol);
			REG_QUAD:  prdata = DATA_W'(cfg_q.quad_bits);
			REG_AMP:   prdata = DATA_W'(cfg_q.amplitude_step);
			REG_PHASE: prdata = DATA_W'(cfg_q.phase_step);
			default:   prdata = '0;
		endcase
	end

endmodule

>>> src/lsm_front.sv
// Symbol decode, level scaling, phase accumulation and quadrant fold.
module lsm_front #(
	parameter int MAX_BITS   = 8,
	parameter int PHASE_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lsm_pkg::lsm_cfg_t        cfg,
	input  logic                     sym_valid,
	output logic                     sym_ready,
	input  logic [lsm_pkg::SYM_W-1:0] symbol,
	output logic                     dn_valid,
	input  logic                     dn_ready,
	output lsm_pkg::lsm_stage_t      dn_data
);
	import lsm_pkg::*;

	localparam int GW = (MAX_BITS > SYM_W) ? MAX_BITS : SYM_W;
	localparam int CW = GW + 2;
	localparam int PW = CW + AMP_W + 1;

	function automatic logic [SYM_W-1:0] gray_dec(input logic [SYM_W-1:0] s);
		logic [SYM_W-1:0] b;
		for (int i = 0; i < SYM_W; i++)
			b[i] = ^(s >> i);
		return b;
	endfunction

	// 2g - 2^bits + 1
	function automatic logic signed [CW-1:0] level_coef(input logic [SYM_W-1:0] g,
			input logic [BPS_W-1:0] bits);
		logic [CW-2:0] pow;
		pow = (CW-1)'(1) << bits;
		return $signed({1'b0, (CW-2)'(g), 1'b1}) - $signed({1'b0, pow});
	endfunction

	logic                   accept;
	logic                   en_s1;
	logic                   en_s2;
	logic [BPS_W-1:0]       m;
	logic [BPS_W-1:0]       mq;
	logic [BPS_W-1:0]       mi;
	logic                   err;
	logic [SYM_W-1:0]       g_all;
	logic [SYM_W-1:0]       g_hi;
	logic [SYM_W-1:0]       g_lo;
	logic signed [CW-1:0]   coef_i;
	logic signed [CW-1:0]   coef_q;
	logic [PHASE_BITS-1:0]  phase_inc;
	logic [PHASE_BITS-1:0]  phase_new;
	logic [PHASE_BITS-1:0]  phase_d;
	logic                   upd_phase;
	kind_t                  kind_d;
	logic signed [SAMP_W-1:0] fix_i_d;
	logic signed [SAMP_W-1:0] fix_q_d;

	logic [PHASE_BITS-1:0]  diff_phase_q;

	logic                   valid_s1;
	kind_t                  kind_s1;
	logic                   err_s1;
	logic signed [SAMP_W-1:0] fix_i_s1;
	logic signed [SAMP_W-1:0] fix_q_s1;
	logic signed [PW-1:0]   prod_i_s1;
	logic signed [PW-1:0]   prod_q_s1;
	logic [PHASE_BITS-1:0]  phase_s1;

	logic                   valid_s2;
	lsm_stage_t             stage_s2;
	lsm_stage_t             stage_d;
	logic [ANG_W-1:0]       p24;
	logic [ANG_W:0]         p_sum;
	logic [2:0]             k3;
	logic signed [ANG_W:0]  z_full;

	assign en_s2     = !valid_s2 || dn_ready;
	assign en_s1     = !valid_s1 || en_s2;
	assign sym_ready = en_s1;
	assign accept    = sym_valid && sym_ready;
	assign dn_valid  = valid_s2;
	assign dn_data   = stage_s2;

	// symbol decode
	always_comb begin
		if (cfg.bits_per_symbol == '0)
			m = BPS_W'(1);
		else if (cfg.bits_per_symbol > BPS_W'(MAX_BITS))
			m = BPS_W'(MAX_BITS);
		else
			m = cfg.bits_per_symbol;
		mq        = (BPS_W'(cfg.quad_bits) > m) ? m : BPS_W'(cfg.quad_bits);
		mi        = m - mq;
		err       = (symbol >> m) != '0;
		g_all     = gray_dec(symbol);
		g_hi      = gray_dec(symbol >> mq);
		g_lo      = gray_dec(symbol & ~(8'hFF << mq));
		phase_inc = PHASE_BITS'(24'(g_all) * 24'(cfg.phase_step));
		phase_new = diff_phase_q + phase_inc;
	end

	always_comb begin
		kind_d    = KIND_FIX;
		fix_i_d   = '0;
		fix_q_d   = '0;
		coef_i    = '0;
		coef_q    = '0;
		phase_d   = phase_inc;
		upd_phase = 1'b0;
		if (!err) begin
			case (cfg.mode)
				MODE_ASK: begin
					kind_d = KIND_LEVEL;
					coef_i = level_coef(g_all, m);
				end
				MODE_QAM: begin
					kind_d = KIND_LEVEL;
					coef_i = level_coef(g_hi, mi);
					coef_q = level_coef(g_lo, mq);
				end
				MODE_PSK: begin
					kind_d = KIND_ROT;
				end
				MODE_DPSK: begin
					kind_d    = KIND_ROT;
					phase_d   = phase_new;
					upd_phase = 1'b1;
				end
				MODE_BPSK: begin
					fix_i_d = (symbol != '0) ? -UNIT_LEVEL : UNIT_LEVEL;
				end
				MODE_QPSK: begin
					fix_i_d = symbol[0] ? -QPSK_LEVEL : QPSK_LEVEL;
					fix_q_d = symbol[1] ? -QPSK_LEVEL : QPSK_LEVEL;
				end
				MODE_OOK: begin
					fix_i_d = (symbol == '0) ? OOK_LEVEL : '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			diff_phase_q <= '0;
		else if (accept && upd_phase)
			diff_phase_q <= phase_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en_s1)
			valid_s1 <= sym_valid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= kind_d;
			err_s1    <= err;
			fix_i_s1  <= fix_i_d;
			fix_q_s1  <= fix_q_d;
			prod_i_s1 <= coef_i * $signed({1'b0, cfg.amplitude_step});
			prod_q_s1 <= coef_q * $signed({1'b0, cfg.amplitude_step});
			phase_s1  <= phase_d;
		end
	end

	// fold the phase to the nearest quarter turn
	always_comb begin
		p24     = ANG_W'(phase_s1) << (ANG_W - PHASE_BITS);
		p_sum   = {1'b0, p24} + (ANG_W+1)'(1 << 21);
		k3      = p_sum[ANG_W:ANG_W-2];
		z_full  = $signed({1'b0, p24}) - $signed({k3, 22'b0});
		stage_d = '0;
		stage_d.err = err_s1;
		case (kind_s1)
			KIND_LEVEL: begin
				stage_d.fix_i = sat16(SAT_W'(prod_i_s1));
				stage_d.fix_q = sat16(SAT_W'(prod_q_s1));
			end
			KIND_ROT: begin
				stage_d.rot  = 1'b1;
				stage_d.quad = k3[1:0];
				stage_d.x    = CORDIC_X0;
				stage_d.z    = z_full[ANG_W-1:0];
			end
			default: begin
				stage_d.fix_i = fix_i_s1;
				stage_d.fix_q = fix_q_s1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (en_s2)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1)
			stage_s2 <= stage_d;
	end

`ifndef SYNTHESIS
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && upd_phase) |=> $stable(diff_phase_q))
		else $error("differential phase moved without a DPSK transaction");
`endif

endmodule

>>> src/lsm_cordic_cell.sv
// One CORDIC micro-rotation with its pipeline register.
module lsm_cordic_cell #(
	parameter int                                STEP = 0,
	parameter logic signed [lsm_pkg::ANG_W-1:0] ATAN = 24'sd0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  lsm_pkg::lsm_stage_t up_data,
	output logic                dn_valid,
	input  logic                dn_ready,
	output lsm_pkg::lsm_stage_t dn_data
);
	import lsm_pkg::*;

	logic                   valid_q;
	lsm_stage_t             data_q;
	lsm_stage_t             data_d;
	logic signed [XY_W-1:0] dx;
	logic signed [XY_W-1:0] dy;

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn_data  = data_q;

	always_comb begin
		dx     = up_data.y >>> STEP;
		dy     = up_data.x >>> STEP;
		data_d = up_data;
		if (!up_data.z[ANG_W-1]) begin
			data_d.x = up_data.x - dx;
			data_d.y = up_data.y + dy;
			data_d.z = up_data.z - ATAN;
		end else begin
			data_d.x = up_data.x + dx;
			data_d.y = up_data.y - dy;
			data_d.z = up_data.z + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (up_ready)
			valid_q <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid)
			data_q <= data_d;
	end

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !dn_ready |=> valid_q && $stable(data_q))
		else $error("CORDIC stage lost or changed a stalled transaction");
`endif

endmodule

>>> src/lsm_back.sv
// Quadrant restore, rounding to Q2.14 and the output register.
module lsm_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       up_valid,
	output logic                       up_ready,
	input  lsm_pkg::lsm_stage_t        up_data,
	output logic                       samp_valid,
	input  logic                       samp_ready,
	output logic signed [lsm_pkg::SAMP_W-1:0] i_out,
	output logic signed [lsm_pkg::SAMP_W-1:0] q_out,
	output logic                       symbol_error
);
	import lsm_pkg::*;

	logic signed [XY_W:0]     xr;
	logic signed [XY_W:0]     yr;
	logic signed [XY_W:0]     xs;
	logic signed [XY_W:0]     ys;
	logic signed [SAMP_W-1:0] i_d;
	logic signed [SAMP_W-1:0] q_d;

	logic                     valid_q;
	logic signed [SAMP_W-1:0] i_q;
	logic signed [SAMP_W-1:0] q_q;
	logic                     err_q;

	assign up_ready     = !valid_q || samp_ready;
	assign samp_valid   = valid_q;
	assign i_out        = i_q;
	assign q_out        = q_q;
	assign symbol_error = err_q;

	always_comb begin
		case (up_data.quad)
			2'd1: begin
				xr = -(XY_W+1)'(up_data.y);
				yr = (XY_W+1)'(up_data.x);
			end
			2'd2: begin
				xr = -(XY_W+1)'(up_data.x);
				yr = -(XY_W+1)'(up_data.y);
			end
			2'd3: begin
				xr = (XY_W+1)'(up_data.y);
				yr = -(XY_W+1)'(up_data.x);
			end
			default: begin
				xr = (XY_W+1)'(up_data.x);
				yr = (XY_W+1)'(up_data.y);
			end
		endcase
		xs = (xr + (XY_W+1)'(32768)) >>> 16;
		ys = (yr + (XY_W+1)'(32768)) >>> 16;
		if (up_data.rot) begin
			i_d = sat16(SAT_W'(xs));
			q_d = sat16(SAT_W'(ys));
		end else begin
			i_d = up_data.fix_i;
			q_d = up_data.fix_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (up_ready)
			valid_q <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			i_q   <= i_d;
			q_q   <= q_d;
			err_q <= up_data.err;
		end
	end

endmodule

>>> src/linear_symbol_mapper_core.sv
// Top level of the linear symbol mapper: registers, decode, CORDIC row, output.
// Maps one symbol a clock, when samp_ready does not stall it, to a signed Q2.14 I/Q
// sample (ASK, QAM, PSK, DPSK, BPSK, QPSK, OOK, chosen by the mode register). Each
// accepted symbol passes two decode/scale stages, one register per CORDIC step in a
// row of 17 cells, and the output register. Throughput is one symbol per cycle in
// every mode while samp_ready holds no stage back; the DPSK phase accumulator is
// updated in the cycle a symbol is taken, so consecutive DPSK symbols need no gap.
// Each stage holds its transaction only while the stage after it is full and stalled,
// so empty slots close up and the input keeps being taken while a finished sample waits at the output.
module linear_symbol_mapper_core #(
	parameter int MAX_BITS   = 8,
	parameter int PHASE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lsm_pkg::ADDR_W-1:0]        paddr,
	input  logic [lsm_pkg::DATA_W-1:0]        pwdata,
	output logic [lsm_pkg::DATA_W-1:0]        prdata,
	output logic                              pready,
	input  logic                              sym_valid,
	output logic                              sym_ready,
	input  logic [lsm_pkg::SYM_W-1:0]         symbol,
	output logic                              samp_valid,
	input  logic                              samp_ready,
	output logic signed [lsm_pkg::SAMP_W-1:0] i_out,
	output logic signed [lsm_pkg::SAMP_W-1:0] q_out,
	output logic                              symbol_error
);
	import lsm_pkg::*;

	lsm_cfg_t   cfg;
	lsm_stage_t chain_data  [CORDIC_STEPS+1];
	logic       chain_valid [CORDIC_STEPS+1];
	logic       chain_ready [CORDIC_STEPS+1];

	lsm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lsm_front #(
		.MAX_BITS   (MAX_BITS),
		.PHASE_BITS (PHASE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.sym_valid (sym_valid),
		.sym_ready (sym_ready),
		.symbol    (symbol),
		.dn_valid  (chain_valid[0]),
		.dn_ready  (chain_ready[0]),
		.dn_data   (chain_data[0])
	);

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		lsm_cordic_cell #(
			.STEP (i),
			.ATAN (ATAN_TURN24[i])
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[i]),
			.up_ready (chain_ready[i]),
			.up_data  (chain_data[i]),
			.dn_valid (chain_valid[i+1]),
			.dn_ready (chain_ready[i+1]),
			.dn_data  (chain_data[i+1])
		);
	end

	lsm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (chain_valid[CORDIC_STEPS]),
		.up_ready     (chain_ready[CORDIC_STEPS]),
		.up_data      (chain_data[CORDIC_STEPS]),
		.samp_valid   (samp_valid),
		.samp_ready   (samp_ready),
		.i_out        (i_out),
		.q_out        (q_out),
		.symbol_error (symbol_error)
	);

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		samp_valid && symbol_error |-> i_out == '0 && q_out == '0)
		else $error("out-of-range symbol produced a non-zero sample");
`endif

endmodule

>>> tb/sv/tb_linear_symbol_mapper_core.sv
// Self-checking testbench for linear_symbol_mapper_core: APB set-up, random I/Q traffic.
module tb_linear_symbol_mapper_core;
	timeunit 1ns;
	timeprecision 1ps;

	import lsm_pkg::*;

	localparam int MAX_BITS = 8;
	localparam int ROT_STEPS = 17;
	localparam int RANDOM_SYMBOLS = 750;
	localparam int CALM_FROM = 640;
	localparam int DRAIN_CYCLES = 25;
	localparam logic [MODE_W-1:0] MODE_RESERVED = 3'd7;
	localparam longint ROT_X0 = 652032874;
	localparam logic signed [15:0] BPSK_AMP = 16'sd16384;
	localparam logic signed [15:0] QPSK_AMP = 16'sd11585;
	localparam logic signed [15:0] OOK_AMP = 16'sd23170;
	// arctan(2^-i) in 2^-24 turn units
	localparam longint ROT_ARC [ROT_STEPS] = '{
		2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
		10430, 5215, 2608, 1304, 652, 326, 163, 81, 41
	};

	typedef struct packed {
		logic [7:0]        sym;
		logic signed [15:0] i_val;
		logic signed [15:0] q_val;
		logic              err;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic sym_valid = 1'b0;
	logic sym_ready;
	logic [SYM_W-1:0] symbol = '0;
	logic samp_valid;
	logic samp_ready = 1'b0;
	logic signed [SAMP_W-1:0] i_out;
	logic signed [SAMP_W-1:0] q_out;
	logic symbol_error;

	// shadow of the block's registers and DPSK phase
	logic [MODE_W-1:0] cfg_mode = MODE_ASK;
	logic [BPS_W-1:0]  cfg_bps = 4'd1;
	logic [QUAD_W-1:0] cfg_quad = 3'd1;
	logic [AMP_W-1:0]  cfg_amp = 15'd16384;
	logic [STEP_W-1:0] cfg_step = 16'd32768;
	logic [STEP_W-1:0] phase_acc = '0;

	logic [7:0] symbol_backlog[$];
	sample_t pending_samples[$];
	bit idle_enable = 1'b1;
	bit sym_accepted = 1'b0;
	int sym_gap = 0;
	int samp_gap = 0;
	int fault_count = 0;

	linear_symbol_mapper_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.sym_valid(sym_valid), .sym_ready(sym_ready), .symbol(symbol),
		.samp_valid(samp_valid), .samp_ready(samp_ready),
		.i_out(i_out), .q_out(q_out), .symbol_error(symbol_error)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic signed [15:0] clip16(input longint v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic [7:0] ungray(input logic [7:0] g);
		logic [7:0] b;
		b = g ^ (g >> 1);
		b = b ^ (b >> 2);
		b = b ^ (b >> 4);
		return b;
	endfunction

	// (2g - M + 1) * alpha for an M = 2^bits level ladder
	function automatic longint ladder(input logic [7:0] g, input int bits);
		return (2 * longint'(g) - (longint'(1) << bits) + 1) * longint'(cfg_amp);
	endfunction

	function automatic void rotate_phase(input logic [15:0] ph,
			output logic signed [15:0] iv, output logic signed [15:0] qv);
		longint p24, k, z, x, y, dx, dy, t;
		int s;
		p24 = longint'(ph) << 8;
		k = (p24 + (longint'(1) << 21)) >> 22;
		z = p24 - k * 4194304;
		x = ROT_X0;
		y = 0;
		for (s = 0; s < ROT_STEPS; s++) begin
			dx = y >>> s;
			dy = x >>> s;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ROT_ARC[s];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ROT_ARC[s];
			end
		end
		case (k & 3)
			1: begin
				t = x;
				x = -y;
				y = t;
			end
			2: begin
				x = -x;
				y = -y;
			end
			3: begin
				t = x;
				x = y;
				y = -t;
			end
			default: ;
		endcase
		iv = clip16((x + 32768) >>> 16);
		qv = clip16((y + 32768) >>> 16);
	endfunction

	// expected I/Q sample for one symbol; advances the DPSK phase for a valid DPSK symbol
	function automatic sample_t map_symbol(input logic [7:0] sym);
		sample_t res;
		int m, mq, mi;
		logic [7:0] g;
		logic [31:0] prod;
		res = '0;
		res.sym = sym;
		m = int'(cfg_bps);
		if (m < 1)
			m = 1;
		if (m > MAX_BITS)
			m = MAX_BITS;
		if (int'(sym) >= (1 << m)) begin
			res.err = 1'b1;
			return res;
		end
		g = ungray(sym);
		prod = 32'(g) * 32'(cfg_step);
		case (cfg_mode)
			MODE_ASK: res.i_val = clip16(ladder(g, m));
			MODE_QAM: begin
				mq = (int'(cfg_quad) > m) ? m : int'(cfg_quad);
				mi = m - mq;
				res.i_val = clip16(ladder(ungray(sym >> mq), mi));
				res.q_val = clip16(ladder(ungray(8'(int'(sym) & ((1 << mq) - 1))),
					mq));
			end
			MODE_PSK: rotate_phase(prod[15:0], res.i_val, res.q_val);
			MODE_DPSK: begin
				phase_acc = phase_acc + prod[15:0];
				rotate_phase(phase_acc, res.i_val, res.q_val);
			end
			MODE_BPSK: res.i_val = (sym != 0) ? -BPSK_AMP : BPSK_AMP;
			MODE_QPSK: begin
				res.i_val = sym[0] ? -QPSK_AMP : QPSK_AMP;
				res.q_val = sym[1] ? -QPSK_AMP : QPSK_AMP;
			end
			MODE_OOK: res.i_val = (sym == 0) ? OOK_AMP : 16'sd0;
			default: ;
		endcase
		return res;
	endfunction

	// symbol side: changes on the falling edge, holds until taken
	always @(negedge clk) begin
		if (arst_n && (!sym_valid || sym_accepted)) begin
			if (sym_gap > 0) begin
				sym_gap = sym_gap - 1;
				sym_valid <= 1'b0;
			end else if (symbol_backlog.size() > 0 && idle_enable
					&& $urandom_range(0, 7) == 0) begin
				sym_gap = $urandom_range(0, 8);
				sym_valid <= 1'b0;
			end else if (symbol_backlog.size() > 0) begin
				symbol <= symbol_backlog.pop_front();
				sym_valid <= 1'b1;
			end else begin
				sym_valid <= 1'b0;
			end
		end
	end

	// sample side back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (samp_gap > 0) begin
				samp_gap = samp_gap - 1;
				samp_ready <= 1'b0;
			end else if (idle_enable && $urandom_range(0, 7) == 0) begin
				samp_gap = $urandom_range(0, 8);
				samp_ready <= 1'b0;
			end else begin
				samp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_samples
		sample_t want;
		if (arst_n) begin
			sym_accepted <= sym_valid && sym_ready;
			if (sym_valid && sym_ready)
				pending_samples.push_back(map_symbol(symbol));
			if (samp_valid && samp_ready) begin
				if (pending_samples.size() == 0) begin
					if (fault_count < 10)
						$display("unexpected sample i=%0d q=%0d err=%0b", i_out, q_out,
							symbol_error);
					fault_count++;
				end else begin
					want = pending_samples.pop_front();
					if (i_out !== want.i_val || q_out !== want.q_val
							|| symbol_error !== want.err) begin
						if (fault_count < 10)
							$display("sample mismatch for symbol %0d: expected i=%0d q=%0d err=%0b,",
								want.sym, $signed(want.i_val), $signed(want.q_val),
								want.err, " got i=%0d q=%0d err=%0b",
								i_out, q_out, symbol_error);
						fault_count++;
					end
				end
			end
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_MODE:  cfg_mode = value[MODE_W-1:0];
			REG_BPS:   cfg_bps = value[BPS_W-1:0];
			REG_QUAD:  cfg_quad = value[QUAD_W-1:0];
			REG_AMP:   cfg_amp = value[AMP_W-1:0];
			REG_PHASE: cfg_step = value[STEP_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(input logic [MODE_W-1:0] md, input logic [BPS_W-1:0] bps,
			input logic [QUAD_W-1:0] quad, input logic [AMP_W-1:0] amp,
			input logic [STEP_W-1:0] step);
		write_reg(REG_MODE, DATA_W'(md));
		write_reg(REG_BPS, DATA_W'(bps));
		write_reg(REG_QUAD, DATA_W'(quad));
		write_reg(REG_AMP, DATA_W'(amp));
		write_reg(REG_PHASE, DATA_W'(step));
	endtask

	// wait for every transaction to come back, then let the pipeline empty
	task automatic settle();
		while (!(symbol_backlog.size() == 0 && !sym_valid && pending_samples.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int sent, n, m, k;
		logic [MODE_W-1:0] md;
		logic [BPS_W-1:0] bps;
		logic [AMP_W-1:0] amp;
		logic [STEP_W-1:0] step;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// reset values: one-bit ASK, then an out-of-range symbol
		symbol_backlog = '{8'd1, 8'd2};
		settle();
		// ASK saturation at full amplitude step
		set_config(MODE_ASK, 4'd8, 3'd1, 15'd32767, 16'd32768);
		symbol_backlog = '{8'd0, 8'd255, 8'd128};
		settle();
		set_config(MODE_QAM, 4'd6, 3'd3, 15'd16384, 16'd0);
		symbol_backlog = '{8'd0, 8'd63, 8'd64};
		settle();
		// quadrature bits above m, then none
		set_config(MODE_QAM, 4'd4, 3'd7, 15'd1000, 16'd0);
		symbol_backlog = '{8'd5};
		settle();
		set_config(MODE_QAM, 4'd4, 3'd0, 15'd1000, 16'd0);
		symbol_backlog = '{8'd9};
		settle();
		set_config(MODE_PSK, 4'd8, 3'd1, 15'd0, 16'd65535);
		symbol_backlog = '{8'd0, 8'd255};
		settle();
		// DPSK: error symbol must leave the phase alone
		set_config(MODE_DPSK, 4'd2, 3'd1, 15'd0, 16'd16384);
		symbol_backlog = '{8'd1, 8'd3, 8'd4, 8'd2};
		settle();
		// symbol widths outside 1..8 are clamped
		set_config(MODE_BPSK, 4'd0, 3'd1, 15'd0, 16'd0);
		symbol_backlog = '{8'd0, 8'd1, 8'd2};
		settle();
		set_config(MODE_QPSK, 4'd15, 3'd1, 15'd0, 16'd0);
		symbol_backlog = '{8'd0, 8'd1, 8'd2, 8'd3};
		settle();
		set_config(MODE_OOK, 4'd3, 3'd1, 15'd0, 16'd0);
		symbol_backlog = '{8'd0, 8'd7};
		settle();
		set_config(MODE_RESERVED, 4'd8, 3'd1, 15'd100, 16'd100);
		symbol_backlog = '{8'd60};
		settle();

		sent = 0;
		while (sent < RANDOM_SYMBOLS) begin
			idle_enable = (sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
			md = MODE_W'($urandom_range(0, 7));
			if ($urandom_range(0, 9) == 0)
				bps = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
			else
				bps = BPS_W'($urandom_range(1, 8));
			case ($urandom_range(0, 5))
				0: amp = '0;
				1: amp = '1;
				default: amp = AMP_W'($urandom_range(0, 32767));
			endcase
			case ($urandom_range(0, 5))
				0: step = '0;
				1: step = '1;
				default: step = STEP_W'($urandom_range(0, 65535));
			endcase
			set_config(md, bps, 3'($urandom_range(0, 7)), amp, step);
			m = (bps < 1) ? 1 : ((bps > MAX_BITS) ? MAX_BITS : int'(bps));
			n = $urandom_range(20, 60);
			for (k = 0; k < n; k++) begin
				if ($urandom_range(0, 7) == 0)
					symbol_backlog.push_back(8'($urandom_range(0, 255)));
				else
					symbol_backlog.push_back(8'($urandom_range(0, (1 << m) - 1)));
			end
			sent += n;
			settle();
		end

		if (fault_count == 0 && pending_samples.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> linear_symbol_mapper_core.f
src/lsm_pkg.sv
src/lsm_regs.sv
src/lsm_front.sv
src/lsm_cordic_cell.sv
src/lsm_back.sv
src/linear_symbol_mapper_core.sv
tb/sv/tb_linear_symbol_mapper_core.sv
